>>> design/prime_sieve_nth_lookup_top_defines.svh
// Assertion macros shared by the prime lookup design files.
// Needs a clock named aclk and an active-low reset named aresetn in the using module.
`ifndef PRIME_SIEVE_NTH_LOOKUP_TOP_DEFINES_SVH
`define PRIME_SIEVE_NTH_LOOKUP_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSNL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSNL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/psnl_pkg.sv
// Shared constants, widths and inter-module structs of the prime lookup block.
// No dependencies; imported by every module of the block.
package psnl_pkg;

    localparam int MAX_LIMIT   = 1023;
    localparam int PRIME_SLOTS = 256;
    localparam int LIMIT_RESET = 1000;
    localparam int FIRST_PRIME = 2;

    localparam int LIMIT_W = 10;
    localparam int INDEX_W = 9;
    localparam int VALUE_W = 10;
    localparam int TOTAL_W = 9;

    localparam int MAP_DEPTH = MAX_LIMIT + 1;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int NUM_W     = MAP_AW + 1;
    localparam int SLOT_AW   = $clog2(PRIME_SLOTS);
    localparam int COUNT_W   = $clog2(PRIME_SLOTS + 1);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - VALUE_W - TOTAL_W;

    typedef struct packed {
        logic start;
    } build_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } build_stat_t;

    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] addr;
        logic [VALUE_W-1:0] data;
    } table_wr_t;

endpackage

>>> design/psnl_sieve.sv
// Sieve engine: clears the composite bitmap, strikes out multiples and compacts the primes.
// Depends on psnl_pkg and the assertion macro header.
`include "prime_sieve_nth_lookup_top_defines.svh"

module psnl_sieve (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psnl_pkg::build_ctrl_t         ctrl,
    input  logic [psnl_pkg::LIMIT_W-1:0]  limit,
    output psnl_pkg::build_stat_t         stat,
    output psnl_pkg::table_wr_t           tbl_wr,
    output logic [psnl_pkg::COUNT_W-1:0]  count
);
    import psnl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_PTEST, S_PREAD, S_MARK, S_CREAD, S_CCHECK, S_DONE
    } state_t;

    state_t               state_reg;
    logic [MAP_AW-1:0]    lim_reg;
    logic [MAP_AW-1:0]    clr_reg;
    logic [NUM_W-1:0]     p_reg;
    logic [NUM_W-1:0]     sq_reg;
    logic [NUM_W-1:0]     k_reg;
    logic [NUM_W-1:0]     n_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic                 map_mem [MAP_DEPTH];
    logic                 map_rdata_reg;

    logic                 map_we;
    logic [MAP_AW-1:0]    map_waddr;
    logic                 map_wdata;
    logic                 map_re;
    logic [MAP_AW-1:0]    map_raddr;

    logic [MAP_AW-1:0]    lim_clamp;
    logic [NUM_W-1:0]     lim_ext;
    logic [NUM_W-1:0]     sq_next;

    assign lim_clamp = (32'(limit) > MAX_LIMIT) ? MAP_AW'(MAX_LIMIT) : MAP_AW'(limit);
    assign lim_ext   = NUM_W'(lim_reg);
    // (p+1)^2 from p^2 without a multiplier.
    assign sq_next   = sq_reg + (p_reg << 1) + NUM_W'(1);

    // The sequencer issues one access per state, so a read never overlaps a pending
    // write to the same entry and no forwarding is needed.
    always_comb begin
        map_we    = 1'b0;
        map_waddr = clr_reg;
        map_wdata = 1'b0;
        map_re    = 1'b0;
        map_raddr = p_reg[MAP_AW-1:0];
        unique case (state_reg)
            S_CLEAR: begin
                map_we = 1'b1;
            end
            S_PTEST: begin
                map_re = (sq_reg <= lim_ext);
            end
            S_MARK: begin
                map_we    = (k_reg <= lim_ext);
                map_waddr = k_reg[MAP_AW-1:0];
                map_wdata = 1'b1;
            end
            S_CREAD: begin
                map_re    = (n_reg <= lim_ext);
                map_raddr = n_reg[MAP_AW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            map_rdata_reg <= map_mem[map_raddr];
        end
    end

    assign tbl_wr.en   = (state_reg == S_CCHECK) && !map_rdata_reg
                         && (count_reg < COUNT_W'(PRIME_SLOTS));
    assign tbl_wr.addr = count_reg[SLOT_AW-1:0];
    assign tbl_wr.data = VALUE_W'(n_reg);

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (ctrl.start) begin
                        lim_reg   <= lim_clamp;
                        clr_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (clr_reg == MAP_AW'(MAX_LIMIT)) begin
                        p_reg     <= NUM_W'(FIRST_PRIME);
                        sq_reg    <= NUM_W'(FIRST_PRIME * FIRST_PRIME);
                        state_reg <= S_PTEST;
                    end else begin
                        clr_reg <= clr_reg + MAP_AW'(1);
                    end
                end
                S_PTEST: begin
                    if (sq_reg <= lim_ext) begin
                        state_reg <= S_PREAD;
                    end else begin
                        n_reg     <= NUM_W'(FIRST_PRIME);
                        state_reg <= S_CREAD;
                    end
                end
                S_PREAD: begin
                    if (map_rdata_reg) begin
                        p_reg     <= p_reg + NUM_W'(1);
                        sq_reg    <= sq_next;
                        state_reg <= S_PTEST;
                    end else begin
                        k_reg     <= sq_reg;
                        state_reg <= S_MARK;
                    end
                end
                S_MARK: begin
                    if (k_reg <= lim_ext) begin
                        k_reg <= k_reg + p_reg;
                    end else begin
                        p_reg     <= p_reg + NUM_W'(1);
                        sq_reg    <= sq_next;
                        state_reg <= S_PTEST;
                    end
                end
                S_CREAD: begin
                    if (n_reg <= lim_ext) begin
                        state_reg <= S_CCHECK;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_CCHECK: begin
                    if (tbl_wr.en) begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                    n_reg     <= n_reg + NUM_W'(1);
                    state_reg <= S_CREAD;
                end
                S_DONE: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `PSNL_ASSERT_IMP(a_tbl_room, tbl_wr.en, count_reg < COUNT_W'(PRIME_SLOTS), "table overrun")
    `PSNL_ASSERT_IMP(a_mark_range, (state_reg == S_MARK) && map_we, k_reg <= lim_ext, "mark beyond limit")
    `PSNL_ASSERT_NEXT(a_start_clear, (state_reg == S_IDLE) && ctrl.start, state_reg == S_CLEAR, "build did not start with a clear")

endmodule

>>> design/psnl_lookup.sv
// Prime table memory, query read and registered result word.
// Depends on psnl_pkg.
module psnl_lookup (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  psnl_pkg::table_wr_t           tbl_wr,
    input  logic                          req_valid,
    input  logic [psnl_pkg::INDEX_W-1:0]  req_index,
    input  logic [psnl_pkg::COUNT_W-1:0]  count,
    output logic                          busy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psnl_pkg::M_TDATA_W-1:0] m_tdata,  // prime_value, prime_total, zero pad
    output logic                          m_tuser   // found
);
    import psnl_pkg::*;

    logic [VALUE_W-1:0] table_mem [PRIME_SLOTS];
    logic [VALUE_W-1:0] rd_data_reg;
    logic               hit_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               pend_reg;

    logic               m_tvalid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_found_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic [SLOT_AW-1:0] rd_addr;
    logic               hit;
    logic               load;

    // An index of zero wraps the address; the entry read is then masked by the miss.
    assign rd_addr = SLOT_AW'(req_index - INDEX_W'(1));
    assign hit     = (req_index != '0) && (32'(req_index) <= 32'(count));
    assign load    = pend_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (tbl_wr.en) begin
            table_mem[tbl_wr.addr] <= tbl_wr.data;
        end
        if (req_valid) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (req_valid) begin
                hit_reg   <= hit;
                total_reg <= TOTAL_W'(count);
                pend_reg  <= 1'b1;
            end else if (load) begin
                pend_reg <= 1'b0;
            end
            if (load) begin
                m_tvalid_reg  <= 1'b1;
                out_value_reg <= hit_reg ? rd_data_reg : '0;
                out_found_reg <= hit_reg;
                out_total_reg <= total_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign busy     = pend_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_total_reg, out_value_reg};
    assign m_tuser  = out_found_reg;

endmodule

>>> design/prime_sieve_nth_lookup_top.sv
// With a built table an accepted query is read from the table memory into the read stage,
// then loaded into the output register once that is free; a new query is taken only after
// the previous one has left the read stage. The first query after reset or a limit write
// rebuilds: a clearing pass over all MAX_LIMIT+1 bitmap entries, marking of the multiples
// of each prime base, compaction of the primes. Reset (aresetn, synchronous) sets the
// limit to 1000, marks the table stale, empties the output register; builds clear the bitmap.
`include "prime_sieve_nth_lookup_top_defines.svh"

module prime_sieve_nth_lookup_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [psnl_pkg::S_TDATA_W-1:0] s_tdata,   // prime_index, zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psnl_pkg::M_TDATA_W-1:0] m_tdata,   // prime_value, prime_total, zero pad
    output logic                           m_tuser,   // found
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [psnl_pkg::LIMIT_W-1:0]   cfg_data   // sieve_limit
);
    import psnl_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_BUILD, ST_FETCH} state_t;

    state_t             state_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               table_ready_reg;
    logic [INDEX_W-1:0] pend_index_reg;

    build_ctrl_t        bld_ctrl;
    build_stat_t        bld_stat;
    table_wr_t          tbl_wr;
    logic [COUNT_W-1:0] prime_count;

    logic               lk_busy;
    logic               lk_req_valid;
    logic [INDEX_W-1:0] lk_req_index;
    logic               s_accept;
    logic [INDEX_W-1:0] s_index;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !lk_busy;
    assign s_accept  = s_tvalid && s_tready;
    assign s_index   = s_tdata[INDEX_W-1:0];

    assign bld_ctrl.start = s_accept && !table_ready_reg;
    assign lk_req_valid   = (s_accept && table_ready_reg)
                            || ((state_reg == ST_FETCH) && !lk_busy);
    assign lk_req_index   = (state_reg == ST_FETCH) ? pend_index_reg : s_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            limit_reg       <= LIMIT_W'(LIMIT_RESET);
            table_ready_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (bld_ctrl.start) begin
                        pend_index_reg <= s_index;
                        state_reg      <= ST_BUILD;
                    end
                end
                ST_BUILD: begin
                    if (bld_stat.done) begin
                        table_ready_reg <= 1'b1;
                        state_reg       <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    // Waits here while the previous result still holds the read stage.
                    if (!lk_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (cfg_valid && cfg_ready) begin
                limit_reg       <= cfg_data;
                table_ready_reg <= 1'b0;
            end
        end
    end

    psnl_sieve u_sieve (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (bld_ctrl),
        .limit   (limit_reg),
        .stat    (bld_stat),
        .tbl_wr  (tbl_wr),
        .count   (prime_count)
    );

    psnl_lookup u_lookup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tbl_wr    (tbl_wr),
        .req_valid (lk_req_valid),
        .req_index (lk_req_index),
        .count     (prime_count),
        .busy      (lk_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    `PSNL_ASSERT_IMP(a_req_free, lk_req_valid, !lk_busy, "lookup request while read stage is occupied")
    `PSNL_ASSERT_NEXT(a_done_ready, (state_reg == ST_BUILD) && bld_stat.done, table_ready_reg && (state_reg == ST_FETCH), "build completion not recorded")
    `PSNL_ASSERT_IMP(a_idle_quiet, state_reg == ST_IDLE, !bld_stat.busy, "sieve running while control is idle")

endmodule
